>>> rtl/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fast-packet reassembler package
// Shared status codes, layout constants, structs and the byte locator used by
// the control logic, the message store and the top level.
// ----------------------------------------------------------------------------
package fpr_pkg;

   // Result status codes.
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_STARTED   = 3'd1;
   localparam logic [2:0] ST_CONTINUED = 3'd2;
   localparam logic [2:0] ST_COMPLETED = 3'd3;
   localparam logic [2:0] ST_ABORT     = 3'd4;
   localparam logic [2:0] ST_REFUSED   = 3'd5;

   // Request command codes.
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Bytes carried by the first frame and by every later frame.
   localparam int FIRST_BYTES = 6;
   localparam int NEXT_BYTES  = 7;
   localparam int ROW_BITS    = NEXT_BYTES * 8;

   // One row write into the message store.
   typedef struct packed {
      logic                    en;
      logic [5:0]              row;
      logic [NEXT_BYTES-1:0]   ben;
      logic [ROW_BITS-1:0]     data;
   } fpr_wr_type;

   // Result fields produced for one request.
   typedef struct packed {
      logic [2:0] status;
      logic       complete;
      logic [7:0] length;
   } fpr_res_type;

   // Row and column of one message byte in the store.
   typedef struct packed {
      logic [5:0] row;
      logic [2:0] col;
   } fpr_loc_type;

   // Map a byte offset to its row and column. Row 0 holds offsets 0 to 5 and
   // row r holds offsets 6+(r-1)*7 to 12+(r-1)*7. The divide by 7 is a
   // multiply by 293/2048, which is exact for every 8-bit value.
   function automatic fpr_loc_type fpr_locate(input logic [7:0] idx);
      logic [7:0]  x;
      logic [16:0] prod;
      logic [5:0]  q;
      logic [7:0]  r;
      fpr_loc_type loc;
      x    = '0;
      prod = '0;
      q    = '0;
      r    = '0;
      if (idx < 8'(FIRST_BYTES)) begin
         loc.row = '0;
         loc.col = idx[2:0];
      end else begin
         x       = idx - 8'(FIRST_BYTES);
         prod    = 17'(x) * 17'd293;
         q       = prod[16:11];
         r       = x - (8'(q) * 8'(NEXT_BYTES));
         loc.row = q + 6'd1;
         loc.col = r[2:0];
      end
      return loc;
   endfunction

endpackage

>>> rtl/fpr_ifaces.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fast-packet reassembler channels
// Valid/ready interfaces for the request channel and the response channel.
// ----------------------------------------------------------------------------

// Request channel: one CAN frame or one byte read per request.
interface fpr_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [63:0] frame_bytes;
   logic [7:0]  read_index;

   modport source (output valid, output cmd, output frame_bytes, output read_index,
                   input ready);
   modport sink   (input valid, input cmd, input frame_bytes, input read_index,
                   output ready);
endinterface

// Response channel: one result per request.
interface fpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic       complete;
   logic [7:0] message_length;
   logic [7:0] read_byte;

   modport source (output valid, output status, output complete,
                   output message_length, output read_byte, input ready);
   modport sink   (input valid, input status, input complete,
                   input message_length, input read_byte, output ready);
endinterface

>>> rtl/fpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fast-packet reassembler control
// Holds the sequence, expected frame counter and recorded length, decides the
// status of each request and builds the row write for the message store.
// ----------------------------------------------------------------------------
module fpr_ctrl
   import fpr_pkg::*;
#(
   parameter int BUFFER_BYTES = 223
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        cmd,
   input  logic [63:0] frame_bytes,
   output fpr_wr_type  wr,
   output fpr_res_type res
);

   localparam int         ROWS    = BUFFER_BYTES / NEXT_BYTES + 1;
   localparam logic [8:0] BUF_LIM = 9'(BUFFER_BYTES);

   logic [2:0] seq_ff, seq_in;
   logic [5:0] exp_ff, exp_in;
   logic [7:0] len_ff, len_in;

   logic [2:0] head_seq;
   logic [4:0] head_cnt;
   logic [7:0] head_len;
   logic [8:0] base;
   logic [8:0] pos;

   assign head_seq = frame_bytes[7:5];
   assign head_cnt = frame_bytes[4:0];
   assign head_len = frame_bytes[15:8];

   // Frame handling: next state, status and store write.
   always_comb begin
      seq_in       = seq_ff;
      exp_in       = exp_ff;
      len_in       = len_ff;
      res.status   = ST_IDLE;
      res.complete = 1'b0;
      wr.en        = 1'b0;
      wr.row       = '0;
      wr.ben       = '0;
      wr.data      = frame_bytes[63:8];
      base         = 9'(FIRST_BYTES) + (9'(exp_ff) - 9'd1) * 9'(NEXT_BYTES);
      pos          = '0;
      if (cmd == CMD_FRAME) begin
         if (head_cnt == 5'd0) begin
            // First frame restarts assembly.
            seq_in = head_seq;
            exp_in = 6'd1;
            if ({1'b0, head_len} > BUF_LIM) begin
               len_in     = '0;
               res.status = ST_REFUSED;
            end else begin
               len_in     = head_len;
               res.status = ST_STARTED;
               wr.en      = 1'b1;
               wr.ben     = 7'b0111111;
               wr.data    = {8'h00, frame_bytes[63:16]};
            end
         end else if (exp_ff == 6'd0) begin
            res.status = ST_IDLE;
         end else if (exp_ff != {1'b0, head_cnt} || seq_ff != head_seq) begin
            exp_in     = '0;
            len_in     = '0;
            res.status = ST_ABORT;
         end else begin
            // Matching later frame: write the bytes that fall below the length.
            for (int c = 0; c < NEXT_BYTES; c++) begin
               pos       = base + 9'(c);
               wr.ben[c] = (pos < {1'b0, len_ff}) && (pos < BUF_LIM);
            end
            wr.en  = (7'(exp_ff) < 7'(ROWS));
            wr.row = exp_ff;
            if (base + 9'(NEXT_BYTES) >= {1'b0, len_ff}) begin
               exp_in       = '0;
               res.status   = ST_COMPLETED;
               res.complete = 1'b1;
            end else begin
               exp_in     = exp_ff + 6'd1;
               res.status = ST_CONTINUED;
            end
         end
      end
      res.length = len_in;
      wr.en      = wr.en && accept;
   end

   // State registers update only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
         exp_ff <= '0;
         len_ff <= '0;
      end else if (accept) begin
         seq_ff <= seq_in;
         exp_ff <= exp_in;
         len_ff <= len_in;
      end
   end

   // Checks on the assembly state.
   a_first_arms: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_FRAME && head_cnt == 5'd0) |=> (exp_ff == 6'd1))
      else $error("first frame did not arm the next frame");

   a_abort_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && res.status == ST_ABORT) |=> (exp_ff == 6'd0 && len_ff == 8'd0))
      else $error("abort left assembly armed");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, len_ff} <= BUF_LIM))
      else $error("recorded length beyond buffer");

endmodule

>>> rtl/fpr_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fast-packet reassembler message store
// Rows of seven bytes with byte enables; one row write and one registered row
// read per cycle.
// ----------------------------------------------------------------------------
module fpr_buffer
   import fpr_pkg::*;
#(
   parameter int BUFFER_BYTES = 223
) (
   input  logic                clock,
   input  fpr_wr_type          wr,
   input  logic                rd_en,
   input  logic [5:0]          rd_row,
   output logic [ROW_BITS-1:0] rd_data
);

   localparam int ROWS  = BUFFER_BYTES / NEXT_BYTES + 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;

   // Byte-enabled row write.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int c = 0; c < NEXT_BYTES; c++) begin
            if (wr.ben[c]) begin
               mem[wr.row[ROW_W-1:0]][c*8 +: 8] <= wr.data[c*8 +: 8];
            end
         end
      end
   end

   // Registered row read; holds while no read is taken.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row[ROW_W-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fast_packet_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fast-packet reassembler
// Builds one multi-frame fast-packet message from 8-byte CAN payloads and
// returns stored message bytes on read requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_if    in         cmd, frame_bytes, read_index
//  rsp_if    out        status, complete, message_length, read_byte
//
//  One request per cycle unless a response stalls; each is answered next cycle.
//  The rate is set by the single row write and row read of the message store.
//  Reset clears the sequence, frame counter and length; stored bytes are not
//  cleared. A stalled response holds its register and stops new requests
//  only while the response register is full and not taken.
// ----------------------------------------------------------------------------
module fast_packet_reassembler
   import fpr_pkg::*;
#(
   parameter int BUFFER_BYTES = 223
) (
   input  logic      clock,
   input  logic      reset,
   fpr_req_if.sink   req_if,
   fpr_rsp_if.source rsp_if
);

   localparam logic [8:0] BUF_LIM = 9'(BUFFER_BYTES);

   logic                accept;
   fpr_wr_type          wr;
   fpr_res_type         res;
   fpr_loc_type         loc;
   logic                in_range;
   logic                rd_en;
   logic [ROW_BITS-1:0] rd_data;

   logic        rsp_valid_ff, rsp_valid_in;
   fpr_res_type res_ff;
   logic        show_ff;
   logic [2:0]  col_ff;

   // Request handshake.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // Read address decode.
   always_comb begin
      loc      = fpr_locate(req_if.read_index);
      in_range = ({1'b0, req_if.read_index} < BUF_LIM);
      rd_en    = accept && (req_if.cmd == CMD_READ) && in_range;
   end

   fpr_ctrl #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_if.cmd),
      .frame_bytes (req_if.frame_bytes),
      .wr          (wr),
      .res         (res)
   );

   fpr_buffer #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_buffer (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_row  (loc.row),
      .rd_data (rd_data)
   );

   // Response valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff  <= res;
         show_ff <= (req_if.cmd == CMD_READ) && in_range;
         col_ff  <= loc.col;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = res_ff.status;
   assign rsp_if.complete       = res_ff.complete;
   assign rsp_if.message_length = res_ff.length;
   assign rsp_if.read_byte      = show_ff ? rd_data[col_ff*8 +: 8] : 8'h00;

   // Checks on the response path.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_complete_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (res_ff.complete == (res_ff.status == ST_COMPLETED)))
      else $error("complete flag disagrees with status");

   a_read_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && show_ff) |-> (res_ff.status == ST_IDLE))
      else $error("read response carries a frame status");

   a_refused_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (res_ff.status == ST_REFUSED || res_ff.status == ST_ABORT))
      |-> (res_ff.length == 8'd0))
      else $error("refused or aborted message kept a length");

endmodule
